// File: rtl/core/uart_ring_fifos_xon_xoff_unit_assert.svh
// Assertion macros for the UART ring FIFO unit.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef UART_RING_FIFOS_XON_XOFF_UNIT_ASSERT_SVH
`define UART_RING_FIFOS_XON_XOFF_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define URF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define URF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define URF_ASSERT(lbl, prop, msg)
`define URF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/uart_rf_pkg.sv
// Shared codes and constants for the UART ring FIFO unit.
// No dependencies.
package uart_rf_pkg;

  // Request kinds on the input channel.
  localparam logic [1:0] REQ_RX_PUT   = 2'd0;
  localparam logic [1:0] REQ_RX_GET   = 2'd1;
  localparam logic [1:0] REQ_TX_PUT   = 2'd2;
  localparam logic [1:0] REQ_TX_READY = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FLOW_ENABLE = 2'd0;
  localparam logic [1:0] CFG_XOFF_LEVEL  = 2'd1;
  localparam logic [1:0] CFG_XON_LEVEL   = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] XOFF_LEVEL_RST = 8'd192;
  localparam logic [7:0] XON_LEVEL_RST  = 8'd128;

  // Flow control characters and the filler byte.
  localparam logic [7:0] XON_CHAR  = 8'd17;
  localparam logic [7:0] XOFF_CHAR = 8'd19;
  localparam logic [7:0] NO_BYTE   = 8'hFF;

  // A result waiting for its memory read data.
  typedef struct packed {
    logic       ok;
    logic       sel_rx;
    logic       sel_tx;
    logic [7:0] byte_val;
    logic [7:0] level;
    logic       tx_req;
  } pend_t;

endpackage

// File: rtl/core/uart_rf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module uart_rf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/uart_ring_fifos_xon_xoff_unit.sv
// Top level of the UART receive/transmit ring FIFOs with XON/XOFF flow control.
// Depends on uart_rf_pkg, uart_rf_ram and uart_ring_fifos_xon_xoff_unit_assert.svh.
//
//   Channel  | Direction | Handshake           | Payload
//   in_      | input     | in_valid/in_ready   | in_req_type, in_data_byte
//   out_     | output    | out_valid/out_ready | out_ok, out_out_byte, out_level, out_tx_request
//   cfg_     | input     | cfg_we              | cfg_addr, cfg_wdata
//
// Each item updates pointers and flags in the cycle it is taken and issues at most one
// ring memory access; the result waits in the pending register, then moves to the
// output register with the memory read data. Items can be taken every cycle the output is free.
// Synchronous reset restores pointers, flags and configuration; no memory clearing pass.
// A stalled output holds the pending result, and the input stalls behind it.
`include "uart_ring_fifos_xon_xoff_unit_assert.svh"
module uart_ring_fifos_xon_xoff_unit #(
  parameter int RING_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_ok,
  output logic [7:0] out_out_byte,
  output logic [7:0] out_level,
  output logic       out_tx_request,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  import uart_rf_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = (AW > 8) ? AW : 8;

  // Configuration registers.
  logic       flow_en_r;
  logic [7:0] xoff_lvl_r;
  logic [7:0] xon_lvl_r;

  // Ring pointers and flow flags.
  logic [AW-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt;
  logic [AW-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt;
  logic          xon_r, xon_nxt, xoff_r, xoff_nxt;
  logic          flow_pend_r, flow_pend_nxt, tx_req_r, tx_req_nxt;

  // Pending and output stages.
  pend_t      pend_r, pend_nxt;
  logic       pend_vld_r;
  logic       out_vld_r;
  logic       out_ok_r;
  logic [7:0] out_byte_r;
  logic [7:0] out_lvl_r;
  logic       out_txr_r;

  // Memory ports.
  logic       rx_we, rx_re, tx_we, tx_re;
  logic [7:0] rx_rdata, tx_rdata;

  // Occupancy and full tests.
  logic [AW-1:0] rx_occ, tx_occ, rx_occ_inc, tx_occ_inc;
  logic [CW-1:0] rx_occ_w, rx_inc_w, tx_occ_w, tx_inc_w;
  logic          rx_full, tx_full, rx_empty, tx_empty;
  logic          out_free, in_fire;

  assign out_free = !out_vld_r || out_ready;
  assign in_ready = !pend_vld_r || out_free;
  assign in_fire  = in_valid && in_ready;

  assign rx_occ     = rx_wr_r - rx_rd_r;
  assign tx_occ     = tx_wr_r - tx_rd_r;
  assign rx_occ_inc = rx_occ + AW'(1);
  assign tx_occ_inc = tx_occ + AW'(1);
  assign rx_full    = (rx_wr_r + AW'(1)) == rx_rd_r;
  assign tx_full    = (tx_wr_r + AW'(1)) == tx_rd_r;
  assign rx_empty   = rx_wr_r == rx_rd_r;
  assign tx_empty   = tx_wr_r == tx_rd_r;
  assign rx_occ_w   = CW'(rx_occ);
  assign rx_inc_w   = CW'(rx_occ_inc);
  assign tx_occ_w   = CW'(tx_occ);
  assign tx_inc_w   = CW'(tx_occ_inc);

  // Per-item decode: pointer and flag updates, memory access, pending result.
  always_comb begin
    rx_wr_nxt     = rx_wr_r;
    rx_rd_nxt     = rx_rd_r;
    tx_wr_nxt     = tx_wr_r;
    tx_rd_nxt     = tx_rd_r;
    xon_nxt       = xon_r;
    xoff_nxt      = xoff_r;
    flow_pend_nxt = flow_pend_r;
    tx_req_nxt    = tx_req_r;
    rx_we         = 1'b0;
    rx_re         = 1'b0;
    tx_we         = 1'b0;
    tx_re         = 1'b0;
    pend_nxt          = '0;
    pend_nxt.byte_val = NO_BYTE;
    if (in_fire) begin
      case (in_req_type)
        REQ_RX_PUT: begin
          if (!rx_full) begin
            rx_we          = 1'b1;
            rx_wr_nxt      = rx_wr_r + AW'(1);
            pend_nxt.ok    = 1'b1;
            pend_nxt.level = rx_inc_w[7:0];
          end
        end
        REQ_RX_GET: begin
          if (!rx_empty) begin
            rx_re           = 1'b1;
            rx_rd_nxt       = rx_rd_r + AW'(1);
            pend_nxt.ok     = 1'b1;
            pend_nxt.sel_rx = 1'b1;
            pend_nxt.level  = rx_occ_w[7:0];
          end
          // Hysteresis on the occupancy before the pop (zero when empty).
          if (flow_en_r) begin
            if (rx_occ_w >= CW'(xoff_lvl_r)) begin
              xon_nxt = 1'b0;
              if (!xoff_r) begin
                xoff_nxt      = 1'b1;
                flow_pend_nxt = 1'b1;
                tx_req_nxt    = 1'b1;
              end
            end else if (rx_occ_w <= CW'(xon_lvl_r)) begin
              xoff_nxt = 1'b0;
              if (!xon_r) begin
                xon_nxt       = 1'b1;
                flow_pend_nxt = 1'b1;
                tx_req_nxt    = 1'b1;
              end
            end
          end
        end
        REQ_TX_PUT: begin
          if (!tx_full) begin
            tx_we          = 1'b1;
            tx_wr_nxt      = tx_wr_r + AW'(1);
            pend_nxt.ok    = 1'b1;
            pend_nxt.level = tx_inc_w[7:0];
            if (tx_empty) begin
              tx_req_nxt = 1'b1;
            end
          end
        end
        REQ_TX_READY: begin
          if (tx_req_r) begin
            if (flow_pend_r) begin
              pend_nxt.ok       = 1'b1;
              pend_nxt.byte_val = xon_r ? XON_CHAR : XOFF_CHAR;
              flow_pend_nxt     = 1'b0;
            end else if (!tx_empty) begin
              tx_re           = 1'b1;
              tx_rd_nxt       = tx_rd_r + AW'(1);
              pend_nxt.ok     = 1'b1;
              pend_nxt.sel_tx = 1'b1;
              pend_nxt.level  = tx_occ_w[7:0];
            end else begin
              tx_req_nxt = 1'b0;
            end
          end
        end
        default: begin
          pend_nxt.ok = 1'b0;
        end
      endcase
      pend_nxt.tx_req = tx_req_nxt;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_en_r   <= 1'b1;
      xoff_lvl_r  <= XOFF_LEVEL_RST;
      xon_lvl_r   <= XON_LEVEL_RST;
      rx_wr_r     <= '0;
      rx_rd_r     <= '0;
      tx_wr_r     <= '0;
      tx_rd_r     <= '0;
      xon_r       <= 1'b1;
      xoff_r      <= 1'b0;
      flow_pend_r <= 1'b0;
      tx_req_r    <= 1'b1;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FLOW_ENABLE: flow_en_r  <= cfg_wdata[0];
          CFG_XOFF_LEVEL:  xoff_lvl_r <= cfg_wdata;
          CFG_XON_LEVEL:   xon_lvl_r  <= cfg_wdata;
          default:         flow_en_r  <= flow_en_r;
        endcase
      end
      rx_wr_r     <= rx_wr_nxt;
      rx_rd_r     <= rx_rd_nxt;
      tx_wr_r     <= tx_wr_nxt;
      tx_rd_r     <= tx_rd_nxt;
      xon_r       <= xon_nxt;
      xoff_r      <= xoff_nxt;
      flow_pend_r <= flow_pend_nxt;
      tx_req_r    <= tx_req_nxt;
      if (in_fire) begin
        pend_vld_r <= 1'b1;
      end else if (out_free) begin
        pend_vld_r <= 1'b0;
      end
      if (out_free) begin
        out_vld_r <= pend_vld_r;
      end
    end
  end

  // Payload of the pending and output stages.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= pend_nxt;
    end
    if (out_free && pend_vld_r) begin
      out_ok_r  <= pend_r.ok;
      out_lvl_r <= pend_r.level;
      out_txr_r <= pend_r.tx_req;
      if (pend_r.sel_rx) begin
        out_byte_r <= rx_rdata;
      end else if (pend_r.sel_tx) begin
        out_byte_r <= tx_rdata;
      end else begin
        out_byte_r <= pend_r.byte_val;
      end
    end
  end

  assign out_valid      = out_vld_r;
  assign out_ok         = out_ok_r;
  assign out_out_byte   = out_byte_r;
  assign out_level      = out_lvl_r;
  assign out_tx_request = out_txr_r;

  // Receive ring memory.
  uart_rf_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(rx_wr_r),
    .wdata(in_data_byte),
    .re   (rx_re),
    .raddr(rx_rd_r),
    .rdata(rx_rdata)
  );

  // Transmit ring memory.
  uart_rf_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_tx_ram (
    .clk  (clk),
    .we   (tx_we),
    .waddr(tx_wr_r),
    .wdata(in_data_byte),
    .re   (tx_re),
    .raddr(tx_rd_r),
    .rdata(tx_rdata)
  );

  // Design checks.
  `URF_ASSERT(a_flags_exclusive, !(xon_r && xoff_r), "XON and XOFF states both set")
  `URF_ASSERT(a_pend_needs_req, flow_pend_r |-> tx_req_r, "flow byte pending without request")
  `URF_ASSERT(a_rx_full_drop, (in_fire && in_req_type == REQ_RX_PUT && rx_full) |=> $stable(rx_wr_r), "write pointer moved on full ring")
  `URF_ASSERT(a_pend_hold, (pend_vld_r && !out_free) |=> (pend_vld_r && $stable(pend_r)), "pending result lost under stall")
  `URF_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_vld_r, "output valid after reset")

endmodule
